// ===== rtl/core/ipv4hc_pkg.sv =====
// ipv4hc_pkg: shared types and constants of the IPv4 header checker
// holds verdict codes, option type codes and the result word layout
// no dependencies
package ipv4hc_pkg;

    // smallest legal header, in bytes
    localparam logic [5:0] MIN_HEADER_BYTES = 6'd20;

    // verdict codes
    typedef logic [2:0] verdict_t;
    localparam verdict_t VERDICT_OK        = 3'd0;
    localparam verdict_t VERDICT_BAD_VER   = 3'd1;
    localparam verdict_t VERDICT_TOO_SMALL = 3'd2;
    localparam verdict_t VERDICT_BAD_IHL   = 3'd3;
    localparam verdict_t VERDICT_TTL_ZERO  = 3'd4;
    localparam verdict_t VERDICT_BAD_CSUM  = 3'd5;

    // option type codes
    localparam logic [7:0] OPT_END         = 8'h00;
    localparam logic [7:0] OPT_NOP         = 8'h01;
    localparam logic [7:0] OPT_LOOSE_ROUTE = 8'h83;

    // version value accepted
    localparam logic [3:0] IP_VERSION      = 4'd4;

    // folded ones-complement sum of a correct header
    localparam logic [16:0] CSUM_GOOD      = 17'h0ffff;

    // one verdict word
    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [7:0]  ttl_value;
        logic [5:0]  header_bytes;
        logic        route_used;
    } result_t;

endpackage

// ===== rtl/core/ipv4hc_ifs.sv =====
// ipv4hc_ifs: valid/ready channel interfaces of the IPv4 header checker
// byte input channel and verdict output channel; uses ipv4hc_pkg
interface ipv4hc_byte_if
    import ipv4hc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ipv4hc_verdict_if
    import ipv4hc_pkg::*;
();
    logic        valid;
    logic        ready;
    verdict_t    verdict;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] total_length;
    logic [7:0]  protocol;
    logic [7:0]  ttl_value;
    logic [5:0]  header_bytes;
    logic        route_used;

    modport source (
        output valid, output verdict, output src_addr, output dst_addr,
        output total_length, output protocol, output ttl_value,
        output header_bytes, output route_used, input ready
    );
    modport sink (
        input valid, input verdict, input src_addr, input dst_addr,
        input total_length, input protocol, input ttl_value,
        input header_bytes, input route_used, output ready
    );
endinterface

// ===== rtl/core/ipv4_header_checker.sv =====
// IPv4 header checker: takes one packet byte per word and gives one verdict
// word per packet. Throughput is one byte per clock cycle while byte_in.ready
// is high, with no gaps between packets; all per-byte work (field capture,
// 16-bit checksum add and fold, option walk, verdict) is one level of logic
// ahead of the state registers. The deciding byte writes the verdict word into
// the main output entry, which drives verdict_out, or into the skid entry
// while an earlier word waits there. That byte completes the header (IHL*4
// bytes, or 20 bytes when IHL is below 5), or it is the last byte if that
// comes first. A two-entry output buffer decouples the sides; byte_in.ready
// drops only while both entries hold verdicts not yet taken. Bytes after the
// verdict are counted and dropped. Depends on ipv4hc_pkg and ipv4hc_ifs.
module ipv4_header_checker
    import ipv4hc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    ipv4hc_byte_if.sink             byte_in,
    ipv4hc_verdict_if.source        verdict_out
);

    // option walk phases
    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_STOP = 2'd3;

    // packet state
    logic [5:0]  byte_count_reg,      byte_count_next;
    logic        verdict_sent_reg,    verdict_sent_next;
    logic [7:0]  version_ihl_reg,     version_ihl_next;
    logic [7:0]  ttl_reg,             ttl_next;
    logic [7:0]  proto_reg,           proto_next;
    logic [15:0] length_reg,          length_next;
    logic [31:0] source_reg,          source_next;
    logic [31:0] dest_reg,            dest_next;
    logic [16:0] sum_acc_reg,         sum_acc_next;
    logic [7:0]  high_byte_hold_reg,  high_byte_hold_next;
    logic [1:0]  option_phase_reg,    option_phase_next;
    logic [7:0]  option_left_reg,     option_left_next;
    logic [7:0]  option_offset_reg,   option_offset_next;
    logic        in_route_option_reg, in_route_option_next;
    logic [31:0] route_addr_reg,      route_addr_next;
    logic        route_valid_reg,     route_valid_next;

    // output buffer
    logic        main_valid_reg;
    logic        skid_valid_reg;
    result_t     main_reg;
    result_t     skid_reg;

    logic        accept;
    logic        pop;
    logic        emit;
    logic [7:0]  b;
    logic [7:0]  vi_eff;
    logic [3:0]  ihl;
    logic [5:0]  hl;
    logic [5:0]  count_inc;
    logic [5:0]  end_point;
    logic [17:0] word_sum;
    verdict_t    verdict_new;
    result_t     result_new;

    assign b        = byte_in.data_byte;
    assign accept   = byte_in.valid && byte_in.ready;
    assign pop      = main_valid_reg && verdict_out.ready;
    assign byte_in.ready = !skid_valid_reg;

    // header length from the current or stored first byte
    assign vi_eff    = (byte_count_reg == 6'd0) ? b : version_ihl_reg;
    assign ihl       = vi_eff[3:0];
    assign hl        = {ihl, 2'b00};
    assign count_inc = (byte_count_reg != 6'd63) ? byte_count_reg + 6'd1 : 6'd63;
    assign end_point = (ihl >= 4'd5) ? hl : MIN_HEADER_BYTES;
    assign word_sum  = {1'b0, sum_acc_reg} + {2'b00, high_byte_hold_reg, b};

    // per-byte state update
    always_comb
    begin
        byte_count_next      = byte_count_reg;
        verdict_sent_next    = verdict_sent_reg;
        version_ihl_next     = version_ihl_reg;
        ttl_next             = ttl_reg;
        proto_next           = proto_reg;
        length_next          = length_reg;
        source_next          = source_reg;
        dest_next            = dest_reg;
        sum_acc_next         = sum_acc_reg;
        high_byte_hold_next  = high_byte_hold_reg;
        option_phase_next    = option_phase_reg;
        option_left_next     = option_left_reg;
        option_offset_next   = option_offset_reg;
        in_route_option_next = in_route_option_reg;
        route_addr_next      = route_addr_reg;
        route_valid_next     = route_valid_reg;

        if (accept)
        begin
            version_ihl_next = vi_eff;
            if (!verdict_sent_reg)
            begin
                // fixed header fields
                if (byte_count_reg == 6'd2)
                    length_next = {b, 8'h00};
                if (byte_count_reg == 6'd3)
                    length_next = {length_reg[15:8], b};
                if (byte_count_reg == 6'd8)
                    ttl_next = b;
                if (byte_count_reg == 6'd9)
                    proto_next = b;
                if (byte_count_reg >= 6'd12 && byte_count_reg <= 6'd15)
                    source_next = {source_reg[23:0], b};
                if (byte_count_reg >= 6'd16 && byte_count_reg <= 6'd19)
                    dest_next = {dest_reg[23:0], b};

                if (byte_count_reg < hl)
                begin
                    // checksum over big-endian 16-bit words
                    if (!byte_count_reg[0])
                        high_byte_hold_next = b;
                    else
                        sum_acc_next = {1'b0, word_sum[15:0]} + {15'd0, word_sum[17:16]};

                    // option walk
                    if (byte_count_reg >= MIN_HEADER_BYTES)
                    begin
                        unique case (option_phase_reg)
                            PH_TYPE:
                            begin
                                if (b == OPT_END)
                                    option_phase_next = PH_STOP;
                                else if (b != OPT_NOP)
                                begin
                                    in_route_option_next = (b == OPT_LOOSE_ROUTE);
                                    option_phase_next    = PH_LEN;
                                end
                            end
                            PH_LEN:
                            begin
                                if (b < 8'd2)
                                    option_phase_next = PH_STOP;
                                else if (b == 8'd2)
                                    option_phase_next = PH_TYPE;
                                else
                                begin
                                    option_left_next   = b - 8'd2;
                                    option_offset_next = 8'd2;
                                    option_phase_next  = PH_BODY;
                                end
                            end
                            PH_BODY:
                            begin
                                if (in_route_option_reg && !route_valid_reg)
                                begin
                                    if (option_offset_reg == 8'd3)
                                        route_addr_next = {24'd0, b};
                                    else if (option_offset_reg >= 8'd4 &&
                                             option_offset_reg <= 8'd6)
                                        route_addr_next = {route_addr_reg[23:0], b};
                                    if (option_offset_reg == 8'd6)
                                        route_valid_next = 1'b1;
                                end
                                option_offset_next = option_offset_reg + 8'd1;
                                option_left_next   = option_left_reg - 8'd1;
                                if (option_left_reg == 8'd1)
                                    option_phase_next = PH_TYPE;
                            end
                            default:
                            begin
                                option_phase_next = PH_STOP;
                            end
                        endcase
                    end
                end
            end

            byte_count_next = count_inc;
            if (emit)
                verdict_sent_next = 1'b1;
        end
    end

    // verdict for this byte, from the updated header state
    assign emit = accept && !verdict_sent_reg &&
                  ((count_inc == end_point) || byte_in.last);

    always_comb
    begin
        priority if (vi_eff[7:4] != IP_VERSION)
            verdict_new = VERDICT_BAD_VER;
        else if (count_inc < MIN_HEADER_BYTES)
            verdict_new = VERDICT_TOO_SMALL;
        else if (ihl < 4'd5)
            verdict_new = VERDICT_BAD_IHL;
        else if (count_inc < hl)
            verdict_new = VERDICT_TOO_SMALL;
        else if (ttl_next == 8'd0)
            verdict_new = VERDICT_TTL_ZERO;
        else if (sum_acc_next != CSUM_GOOD)
            verdict_new = VERDICT_BAD_CSUM;
        else
            verdict_new = VERDICT_OK;
    end

    // result word; route needs an ok verdict
    always_comb
    begin
        result_new.verdict      = verdict_new;
        result_new.src_addr     = source_next;
        result_new.route_used   = (verdict_new == VERDICT_OK) && route_valid_next;
        result_new.dst_addr     = result_new.route_used ? route_addr_next : dest_next;
        result_new.total_length = length_next;
        result_new.protocol     = proto_next;
        result_new.ttl_value    = ttl_next;
        result_new.header_bytes = hl;
    end

    // packet state registers; packet end returns everything to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= '0;
            verdict_sent_reg    <= 1'b0;
            version_ihl_reg     <= '0;
            ttl_reg             <= '0;
            proto_reg           <= '0;
            length_reg          <= '0;
            source_reg          <= '0;
            dest_reg            <= '0;
            sum_acc_reg         <= '0;
            high_byte_hold_reg  <= '0;
            option_phase_reg    <= PH_TYPE;
            option_left_reg     <= '0;
            option_offset_reg   <= '0;
            in_route_option_reg <= 1'b0;
            route_addr_reg      <= '0;
            route_valid_reg     <= 1'b0;
        end
        else if (accept && byte_in.last)
        begin
            byte_count_reg      <= '0;
            verdict_sent_reg    <= 1'b0;
            version_ihl_reg     <= '0;
            ttl_reg             <= '0;
            proto_reg           <= '0;
            length_reg          <= '0;
            source_reg          <= '0;
            dest_reg            <= '0;
            sum_acc_reg         <= '0;
            high_byte_hold_reg  <= '0;
            option_phase_reg    <= PH_TYPE;
            option_left_reg     <= '0;
            option_offset_reg   <= '0;
            in_route_option_reg <= 1'b0;
            route_addr_reg      <= '0;
            route_valid_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg      <= byte_count_next;
            verdict_sent_reg    <= verdict_sent_next;
            version_ihl_reg     <= version_ihl_next;
            ttl_reg             <= ttl_next;
            proto_reg           <= proto_next;
            length_reg          <= length_next;
            source_reg          <= source_next;
            dest_reg            <= dest_next;
            sum_acc_reg         <= sum_acc_next;
            high_byte_hold_reg  <= high_byte_hold_next;
            option_phase_reg    <= option_phase_next;
            option_left_reg     <= option_left_next;
            option_offset_reg   <= option_offset_next;
            in_route_option_reg <= in_route_option_next;
            route_addr_reg      <= route_addr_next;
            route_valid_reg     <= route_valid_next;
        end
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                main_valid_reg <= emit;
        end
        else if (emit)
            skid_valid_reg <= 1'b1;
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (emit)
                main_reg <= result_new;
        end
        else if (emit)
            skid_reg <= result_new;
    end

    assign verdict_out.valid        = main_valid_reg;
    assign verdict_out.verdict      = main_reg.verdict;
    assign verdict_out.src_addr     = main_reg.src_addr;
    assign verdict_out.dst_addr     = main_reg.dst_addr;
    assign verdict_out.total_length = main_reg.total_length;
    assign verdict_out.protocol     = main_reg.protocol;
    assign verdict_out.ttl_value    = main_reg.ttl_value;
    assign verdict_out.header_bytes = main_reg.header_bytes;
    assign verdict_out.route_used   = main_reg.route_used;

    // skid entry only fills behind a held main entry
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid while main entry empty");

    // one verdict per packet: a verdict mid-packet blocks further ones
    a_verdict_once: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !byte_in.last) |=> verdict_sent_reg)
        else $error("verdict not marked sent");

    // packet end returns the walker to its start
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_in.last) |=>
            (byte_count_reg == 6'd0 && !verdict_sent_reg && !route_valid_reg &&
             option_phase_reg == PH_TYPE))
        else $error("state not cleared after last byte");

    // a source route is only reported with an ok verdict
    a_route_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_out.valid && verdict_out.route_used) |->
            (verdict_out.verdict == VERDICT_OK))
        else $error("route used on failing verdict");

endmodule

// ===== sim/ipv4_header_checker_tb.sv =====
// testbench for ipv4_header_checker: byte stream in, one verdict word per packet out
// depends on ipv4hc_pkg, ipv4hc_ifs and the ipv4_header_checker rtl
`timescale 1ns / 1ps

module ipv4_header_checker_tb;

    import ipv4hc_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BYTES   = 140;
    localparam int RANDOM_PACKETS = 6;

    // loose source route option: offsets of the first address within the option
    localparam int ROUTE_ADDR_FIRST = 3;
    localparam int ROUTE_ADDR_LAST  = 6;

    // flow control setting carried along with each byte
    typedef enum logic [1:0] {
        MODE_SLOW_SINK,
        MODE_SLOW_SOURCE,
        MODE_HOLD_SINK,
        MODE_STREAM
    } mode_t;

    // option walk position
    typedef enum logic [1:0] {
        WALK_TYPE,
        WALK_LEN,
        WALK_BODY,
        WALK_STOP
    } walk_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        mode_t      mode;
    } word_t;

    logic clk;
    logic rst_n;

    ipv4hc_byte_if    byte_ch ();
    ipv4hc_verdict_if verdict_ch ();

    ipv4_header_checker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_in     (byte_ch),
        .verdict_out (verdict_ch)
    );

    // stimulus and expected verdicts
    word_t      byte_stream[$];
    result_t    verdicts_due[$];
    logic [7:0] pkt[$];
    word_t      next_word;
    mode_t      cur_mode;

    // header parser state of the predictor
    logic [5:0]  hdr_count;
    bit          hdr_sent;
    logic [7:0]  hdr_ver_ihl;
    logic [7:0]  hdr_ttl;
    logic [7:0]  hdr_proto;
    logic [15:0] hdr_len;
    logic [31:0] hdr_src;
    logic [31:0] hdr_dst;
    logic [16:0] hdr_sum;
    logic [7:0]  hdr_hold;
    walk_t       walk_state;
    logic [7:0]  walk_left;
    logic [7:0]  walk_pos;
    bit          walk_in_route;
    logic [31:0] lsr_addr;
    bit          lsr_found;

    // bookkeeping
    int      mismatches;
    int      packets_sent;
    int      bytes_sent;
    int      verdicts_checked;
    int      routes_taken;
    int      verdict_tally[0:7];
    int      quiet_cycles;
    int      hold_left;
    bit      hold_done;
    result_t due_now;
    result_t seen;
    result_t want;
    string   diffs;

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void clear_header();
        hdr_count     = '0;
        hdr_sent      = 1'b0;
        hdr_ver_ihl   = '0;
        hdr_ttl       = '0;
        hdr_proto     = '0;
        hdr_len       = '0;
        hdr_src       = '0;
        hdr_dst       = '0;
        hdr_sum       = '0;
        hdr_hold      = '0;
        walk_state    = WALK_TYPE;
        walk_left     = '0;
        walk_pos      = '0;
        walk_in_route = 1'b0;
        lsr_addr      = '0;
        lsr_found     = 1'b0;
    endfunction

    // one option byte; only the first complete loose source route is taken
    function automatic void walk_option(logic [7:0] b);
        case (walk_state)
            WALK_TYPE:
            begin
                if (b == OPT_END)
                    walk_state = WALK_STOP;
                else if (b != OPT_NOP)
                begin
                    walk_in_route = (b == OPT_LOOSE_ROUTE);
                    walk_state    = WALK_LEN;
                end
            end
            WALK_LEN:
            begin
                if (b < 8'd2)
                    walk_state = WALK_STOP;
                else if (b == 8'd2)
                    walk_state = WALK_TYPE;
                else
                begin
                    walk_left  = b - 8'd2;
                    walk_pos   = 8'd2;
                    walk_state = WALK_BODY;
                end
            end
            WALK_BODY:
            begin
                if (walk_in_route && !lsr_found)
                begin
                    if (walk_pos == ROUTE_ADDR_FIRST)
                        lsr_addr = {24'h0, b};
                    else if (walk_pos > ROUTE_ADDR_FIRST && walk_pos <= ROUTE_ADDR_LAST)
                        lsr_addr = {lsr_addr[23:0], b};
                    if (walk_pos == ROUTE_ADDR_LAST)
                        lsr_found = 1'b1;
                end
                walk_pos  = walk_pos + 8'd1;
                walk_left = walk_left - 8'd1;
                if (walk_left == 8'd0)
                    walk_state = WALK_TYPE;
            end
            default:
                ;
        endcase
    endfunction

    // one accepted byte; returns 1 with the verdict word when this byte decides it
    function automatic bit header_step(input logic [7:0] b, input logic lst,
                                       output result_t r);
        int idx;
        int hl;
        int n;
        int stop;
        int s;
        bit fire;
        idx  = hdr_count;
        fire = 1'b0;
        r    = '0;
        if (idx == 0)
            hdr_ver_ihl = b;
        hl = int'(hdr_ver_ihl[3:0]) * 4;

        // field capture, checksum and option walk until the verdict is out
        if (!hdr_sent)
        begin
            case (idx)
                2: hdr_len = {b, 8'h00};
                3: hdr_len[7:0] = b;
                8: hdr_ttl = b;
                9: hdr_proto = b;
                default: ;
            endcase
            if (idx >= 12 && idx <= 15)
                hdr_src = {hdr_src[23:0], b};
            if (idx >= 16 && idx <= 19)
                hdr_dst = {hdr_dst[23:0], b};
            if (idx < hl)
            begin
                if (idx % 2 == 0)
                    hdr_hold = b;
                else
                begin
                    s       = int'(hdr_sum) + int'({hdr_hold, b});
                    hdr_sum = 17'((s & 32'hffff) + (s >> 16));
                end
                if (idx >= int'(MIN_HEADER_BYTES))
                    walk_option(b);
            end
        end

        n         = (idx < 63) ? idx + 1 : 63;
        hdr_count = 6'(n);
        stop      = (hl >= int'(MIN_HEADER_BYTES)) ? hl : int'(MIN_HEADER_BYTES);

        // verdict in priority order
        if (!hdr_sent && (n == stop || lst))
        begin
            if (hdr_ver_ihl[7:4] != IP_VERSION)
                r.verdict = VERDICT_BAD_VER;
            else if (n < int'(MIN_HEADER_BYTES))
                r.verdict = VERDICT_TOO_SMALL;
            else if (hl < int'(MIN_HEADER_BYTES))
                r.verdict = VERDICT_BAD_IHL;
            else if (n < hl)
                r.verdict = VERDICT_TOO_SMALL;
            else if (hdr_ttl == 8'h00)
                r.verdict = VERDICT_TTL_ZERO;
            else if (hdr_sum != CSUM_GOOD)
                r.verdict = VERDICT_BAD_CSUM;
            else
                r.verdict = VERDICT_OK;
            r.route_used   = (r.verdict == VERDICT_OK) && lsr_found;
            r.src_addr     = hdr_src;
            r.dst_addr     = r.route_used ? lsr_addr : hdr_dst;
            r.total_length = hdr_len;
            r.protocol     = hdr_proto;
            r.ttl_value    = hdr_ttl;
            r.header_bytes = 6'(hl);
            hdr_sent       = 1'b1;
            fire           = 1'b1;
        end
        if (lst)
            clear_header();
        return fire;
    endfunction

    // packet construction
    function automatic void start_header(logic [3:0] ver, logic [3:0] ihl, logic [7:0] ttl,
                                         logic [7:0] proto, logic [15:0] tlen,
                                         logic [31:0] src, logic [31:0] dst);
        pkt.delete();
        pkt.push_back({ver, ihl});
        pkt.push_back(8'($urandom));
        pkt.push_back(tlen[15:8]);
        pkt.push_back(tlen[7:0]);
        repeat (4) pkt.push_back(8'($urandom));
        pkt.push_back(ttl);
        pkt.push_back(proto);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        for (int i = 3; i >= 0; i--)
            pkt.push_back(src[i*8 +: 8]);
        for (int i = 3; i >= 0; i--)
            pkt.push_back(dst[i*8 +: 8]);
    endfunction

    // pad the option area with end bytes, or cut it back, to the header length
    function automatic void finish_options();
        int hl;
        hl = int'(pkt[0][3:0]) * 4;
        while (pkt.size() < hl)
            pkt.push_back(OPT_END);
        while (pkt.size() > hl && pkt.size() > int'(MIN_HEADER_BYTES))
            void'(pkt.pop_back());
    endfunction

    function automatic void random_options();
        int hl;
        int len;
        hl = int'(pkt[0][3:0]) * 4;
        while (pkt.size() < hl)
        begin
            case ($urandom_range(9))
                0:
                    pkt.push_back(OPT_END);
                1, 2:
                    pkt.push_back(OPT_NOP);
                3, 4, 5, 6:
                begin
                    len = $urandom_range(3, 19);
                    pkt.push_back(OPT_LOOSE_ROUTE);
                    pkt.push_back(8'(len));
                    pkt.push_back(8'd4);
                    repeat (len - 3) pkt.push_back(8'($urandom));
                end
                7:
                begin
                    len = $urandom_range(2, 8);
                    pkt.push_back(8'($urandom_range(2, 255)));
                    pkt.push_back(8'(len));
                    repeat (len - 2) pkt.push_back(8'($urandom));
                end
                8:
                begin
                    // length too small to be legal
                    pkt.push_back(8'($urandom_range(2, 255)));
                    pkt.push_back(8'($urandom_range(1)));
                end
                default:
                    pkt.push_back(8'($urandom));
            endcase
        end
        finish_options();
    endfunction

    // fill in the header checksum, optionally with one bit flipped
    function automatic void seal_checksum(bit good);
        int hl;
        int acc;
        logic [15:0] cs;
        hl      = int'(pkt[0][3:0]) * 4;
        pkt[10] = 8'h00;
        pkt[11] = 8'h00;
        acc     = 0;
        for (int i = 0; i < hl; i += 2)
        begin
            acc = acc + int'({pkt[i], pkt[i+1]});
            acc = (acc & 32'hffff) + (acc >> 16);
        end
        cs = ~acc[15:0];
        if (!good)
            cs = cs ^ 16'(1 << $urandom_range(15));
        pkt[10] = cs[15:8];
        pkt[11] = cs[7:0];
    endfunction

    function automatic void add_payload(int n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    // queue the packet, cut to its first cut bytes when cut is set
    function automatic void send_packet(int cut, mode_t m);
        int n;
        word_t w;
        n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (int i = 0; i < n; i++)
        begin
            w.data_byte = pkt[i];
            w.last      = (i == n - 1);
            w.mode      = m;
            byte_stream.push_back(w);
        end
        packets_sent++;
        bytes_sent += n;
    endfunction

    // mostly well-formed packets, the rest with one fault each
    function automatic void random_packet(mode_t m);
        int kind;
        int cut;
        logic [3:0] ver;
        logic [3:0] ihl;
        logic [7:0] ttl;
        bit good;
        kind = $urandom_range(99);
        ver  = IP_VERSION;
        ihl  = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(5, 8));
        ttl  = 8'($urandom_range(1, 255));
        good = 1'b1;
        cut  = 0;
        if (kind >= 95)
            cut = $urandom_range(1, 19);
        else if (kind >= 90)
        begin
            ihl = 4'($urandom_range(6, 15));
            cut = $urandom_range(20, int'(ihl) * 4 - 1);
        end
        else if (kind >= 85)
            good = 1'b0;
        else if (kind >= 80)
            ttl = 8'h00;
        else if (kind >= 75)
            ihl = 4'($urandom_range(4));
        else if (kind >= 70)
        begin
            ver = 4'($urandom_range(15));
            if (ver == IP_VERSION)
                ver = ~ver;
        end
        start_header(ver, ihl, ttl, 8'($urandom), 16'($urandom), $urandom, $urandom);
        random_options();
        if (int'(ihl) * 4 >= int'(MIN_HEADER_BYTES))
            seal_checksum(good);
        add_payload(($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 4));
        send_packet(cut, m);
    endfunction

    function automatic bit sender_idles(mode_t m);
        case (m)
            MODE_SLOW_SINK:   return $urandom_range(99) < 27;
            MODE_SLOW_SOURCE: return $urandom_range(99) < 65;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles(mode_t m);
        case (m)
            MODE_SLOW_SINK:   return $urandom_range(99) < 65;
            MODE_SLOW_SOURCE: return $urandom_range(99) < 27;
            default:          return 1'b0;
        endcase
    endfunction

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= 8'h00;
            byte_ch.last      <= 1'b0;
            cur_mode          <= MODE_SLOW_SINK;
        end
        else if (!byte_ch.valid || byte_ch.ready)
        begin
            if (byte_stream.size() != 0 && !sender_idles(byte_stream[0].mode))
            begin
                next_word         = byte_stream.pop_front();
                byte_ch.valid     <= 1'b1;
                byte_ch.data_byte <= next_word.data_byte;
                byte_ch.last      <= next_word.last;
                cur_mode          <= next_word.mode;
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    // verdict ready, with one long hold-off to back up the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_ch.ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (cur_mode == MODE_HOLD_SINK && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                verdict_ch.ready <= 1'b0;
            end
            else
                verdict_ch.ready <= !receiver_idles(cur_mode);
        end
    end

    // predict on each accepted byte, check each accepted verdict word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (header_step(byte_ch.data_byte, byte_ch.last, due_now))
                    verdicts_due.push_back(due_now);
            end
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                seen = '{verdict: verdict_ch.verdict, src_addr: verdict_ch.src_addr,
                         dst_addr: verdict_ch.dst_addr, total_length: verdict_ch.total_length,
                         protocol: verdict_ch.protocol, ttl_value: verdict_ch.ttl_value,
                         header_bytes: verdict_ch.header_bytes,
                         route_used: verdict_ch.route_used};
                if (verdicts_due.size() == 0)
                    report_mismatch($sformatf("verdict word %0d with no packet pending",
                                              seen.verdict));
                else
                begin
                    want  = verdicts_due.pop_front();
                    diffs = "";
                    if (seen.verdict !== want.verdict)
                        diffs = {diffs, $sformatf(" verdict %0d/%0d",
                                                  seen.verdict, want.verdict)};
                    if (seen.src_addr !== want.src_addr)
                        diffs = {diffs, $sformatf(" src %h/%h", seen.src_addr, want.src_addr)};
                    if (seen.dst_addr !== want.dst_addr)
                        diffs = {diffs, $sformatf(" dst %h/%h", seen.dst_addr, want.dst_addr)};
                    if (seen.total_length !== want.total_length)
                        diffs = {diffs, $sformatf(" len %h/%h",
                                                  seen.total_length, want.total_length)};
                    if (seen.protocol !== want.protocol)
                        diffs = {diffs, $sformatf(" proto %h/%h", seen.protocol, want.protocol)};
                    if (seen.ttl_value !== want.ttl_value)
                        diffs = {diffs, $sformatf(" ttl %h/%h", seen.ttl_value, want.ttl_value)};
                    if (seen.header_bytes !== want.header_bytes)
                        diffs = {diffs, $sformatf(" hdr %0d/%0d",
                                                  seen.header_bytes, want.header_bytes)};
                    if (seen.route_used !== want.route_used)
                        diffs = {diffs, $sformatf(" route %b/%b",
                                                  seen.route_used, want.route_used)};
                    if (diffs != "")
                        report_mismatch($sformatf("packet %0d got/expected:%s",
                                                  verdicts_checked, diffs));
                    verdicts_checked++;
                    verdict_tally[want.verdict]++;
                    if (want.route_used)
                        routes_taken++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles, %0d verdicts pending",
                     quiet_cycles, verdicts_due.size());
            $display("ipv4_header_checker_tb failed");
            $finish;
        end
    end

    initial
    begin
        int rand_start;
        int rand_packets;
        mode_t phase;
        rst_n            = 1'b0;
        quiet_cycles     = 0;
        mismatches       = 0;
        packets_sent     = 0;
        bytes_sent       = 0;
        verdicts_checked = 0;
        routes_taken     = 0;
        rand_packets     = 0;
        for (int i = 0; i < 8; i++)
            verdict_tally[i] = 0;
        clear_header();

        // minimal header with fields at their extremes, last byte on the verdict byte
        start_header(IP_VERSION, 4'd5, 8'hff, 8'hff, 16'hffff, 32'hffff_ffff, 32'h0);
        seal_checksum(1'b1);
        send_packet(0, MODE_SLOW_SINK);

        // ttl of one, payload dropped after the verdict
        start_header(IP_VERSION, 4'd5, 8'h01, 8'h00, 16'h0000, 32'h0, 32'hffff_ffff);
        seal_checksum(1'b1);
        add_payload(3);
        send_packet(0, MODE_SLOW_SINK);

        // largest header, two route options where only the first counts, long payload
        start_header(IP_VERSION, 4'd15, 8'h40, 8'h06, 16'd72, $urandom, $urandom);
        pkt = {pkt, OPT_NOP, OPT_LOOSE_ROUTE, 8'd11, 8'd4, 8'hc0, 8'ha8, 8'h01, 8'h01,
               8'h0a, 8'h00, 8'h00, 8'h01, OPT_LOOSE_ROUTE, 8'd7, 8'd4,
               8'h0a, 8'h0b, 8'h0c, 8'h0d};
        finish_options();
        seal_checksum(1'b1);
        add_payload(12);
        send_packet(0, MODE_SLOW_SINK);

        // other option, route too short for an address, bare option, then bad length
        start_header(IP_VERSION, 4'd9, 8'h80, 8'h11, 16'd36, $urandom, $urandom);
        pkt = {pkt, OPT_NOP, 8'h44, 8'd4, 8'h12, 8'h34, OPT_LOOSE_ROUTE, 8'd6, 8'd4,
               8'haa, 8'hbb, 8'hcc, 8'h07, 8'd2, 8'h20, 8'd1, OPT_LOOSE_ROUTE};
        finish_options();
        seal_checksum(1'b1);
        send_packet(0, MODE_SLOW_SINK);

        // route option that runs past the header end still yields its address
        start_header(IP_VERSION, 4'd7, 8'h20, 8'h06, 16'd30, $urandom, $urandom);
        pkt = {pkt, OPT_LOOSE_ROUTE, 8'd20, 8'd4, 8'hde, 8'had, 8'hbe, 8'hef, 8'h55};
        finish_options();
        seal_checksum(1'b1);
        add_payload(2);
        send_packet(0, MODE_SLOW_SINK);

        // route present but checksum wrong: destination stays as received
        start_header(IP_VERSION, 4'd7, 8'h20, 8'h06, 16'd28, $urandom, $urandom);
        pkt = {pkt, OPT_LOOSE_ROUTE, 8'd7, 8'd4, 8'h01, 8'h02, 8'h03, 8'h04, OPT_END};
        finish_options();
        seal_checksum(1'b0);
        send_packet(0, MODE_SLOW_SINK);

        // ttl expired
        start_header(IP_VERSION, 4'd5, 8'h00, 8'h01, 16'd20, $urandom, $urandom);
        seal_checksum(1'b1);
        send_packet(0, MODE_SLOW_SINK);

        // wrong version
        start_header(4'd6, 4'd5, 8'h10, 8'h01, 16'd20, $urandom, $urandom);
        seal_checksum(1'b1);
        send_packet(0, MODE_SLOW_SINK);

        // ihl below five
        start_header(IP_VERSION, 4'd3, 8'h10, 8'h01, 16'd22, $urandom, $urandom);
        add_payload(2);
        send_packet(0, MODE_SLOW_SINK);

        // packet shorter than a minimal header
        start_header(IP_VERSION, 4'd0, 8'h10, 8'h01, 16'd8, $urandom, $urandom);
        send_packet(8, MODE_SLOW_SINK);

        // single byte packet
        pkt.delete();
        pkt.push_back(8'h00);
        send_packet(0, MODE_SLOW_SINK);

        // header cut short by the last byte
        start_header(IP_VERSION, 4'd10, 8'h33, 8'h06, 16'd40, $urandom, $urandom);
        random_options();
        seal_checksum(1'b1);
        send_packet(30, MODE_SLOW_SINK);

        // end of options stops the walk before a route option
        start_header(IP_VERSION, 4'd6, 8'h33, 8'h06, 16'd24, $urandom, $urandom);
        pkt = {pkt, OPT_END, OPT_LOOSE_ROUTE, 8'd7, 8'd4};
        finish_options();
        seal_checksum(1'b1);
        send_packet(0, MODE_SLOW_SINK);

        // bad version with the largest header gives its verdict at byte 60
        start_header(4'hf, 4'd15, 8'h33, 8'h06, 16'd60, $urandom, $urandom);
        random_options();
        seal_checksum(1'b1);
        send_packet(0, MODE_SLOW_SINK);

        // back pressure: receiver holds off while one-byte packets keep coming
        repeat (12)
        begin
            pkt.delete();
            pkt.push_back(8'($urandom));
            send_packet(0, MODE_HOLD_SINK);
        end

        // random packets in three flow control phases
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RANDOM_BYTES || rand_packets < RANDOM_PACKETS)
        begin
            if (rand_packets < RANDOM_PACKETS / 3)
                phase = MODE_SLOW_SINK;
            else if (rand_packets < 2 * RANDOM_PACKETS / 3)
                phase = MODE_SLOW_SOURCE;
            else
                phase = MODE_STREAM;
            random_packet(phase);
            rand_packets++;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // drain
        while (byte_stream.size() != 0 || byte_ch.valid || verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d packets, %0d bytes, %0d verdict words checked, %0d routed",
                 packets_sent, bytes_sent, verdicts_checked, routes_taken);
        $display("verdicts ok %0d ver %0d short %0d ihl %0d ttl %0d csum %0d, %0d mismatches",
                 verdict_tally[VERDICT_OK], verdict_tally[VERDICT_BAD_VER],
                 verdict_tally[VERDICT_TOO_SMALL], verdict_tally[VERDICT_BAD_IHL],
                 verdict_tally[VERDICT_TTL_ZERO], verdict_tally[VERDICT_BAD_CSUM], mismatches);
        if (mismatches == 0)
            $display("ipv4_header_checker_tb passed");
        else
            $display("ipv4_header_checker_tb failed");
        $finish;
    end

endmodule
